// ===== rtl/swm_pkg.sv =====
package swm_pkg;

  localparam int CFG_BITS = 7;

  typedef struct packed {
    logic flush;
    logic step;
    logic restart;
    logic shift;
  } swm_ctl_t;

endpackage

// ===== rtl/swm_cell.sv =====
module swm_cell
  import swm_pkg::*;
#(
  parameter int DW = 16,
  parameter int AW = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swm_ctl_t             ctl,
  input  logic signed [DW-1:0] sample_i,
  input  logic [AW-1:0]        win_i,
  input  logic                 prev_ok_i,
  input  logic                 nb_valid_i,
  input  logic signed [DW-1:0] nb_value_i,
  input  logic [AW-1:0]        nb_age_i,
  input  logic                 nb_surv_i,
  output logic                 valid_o,
  output logic signed [DW-1:0] value_o,
  output logic [AW-1:0]        age_o,
  output logic                 surv_o
);

  logic                 valid_r, valid_nxt;
  logic signed [DW-1:0] value_r, value_nxt;
  logic [AW-1:0]        age_r, age_nxt;
  logic                 src_valid;
  logic signed [DW-1:0] src_value;
  logic [AW-1:0]        src_age;
  logic                 src_surv;

  // A candidate stays if it is still inside the window and not below the new sample.
  assign surv_o = valid_r && !ctl.restart && (age_r < win_i) && !(sample_i > value_r);

  always_comb begin
    src_valid = ctl.shift ? nb_valid_i : valid_r;
    src_value = ctl.shift ? nb_value_i : value_r;
    src_age   = ctl.shift ? nb_age_i : age_r;
    src_surv  = ctl.shift ? nb_surv_i : surv_o;
    valid_nxt = valid_r;
    value_nxt = value_r;
    age_nxt   = age_r;
    if (ctl.flush) begin
      valid_nxt = 1'b0;
    end else if (ctl.step) begin
      if (src_surv && src_valid) begin
        valid_nxt = 1'b1;
        value_nxt = src_value;
        age_nxt   = src_age + AW'(1);
      end else if (prev_ok_i) begin
        valid_nxt = 1'b1;
        value_nxt = sample_i;
        age_nxt   = AW'(1);
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

  assign valid_o = valid_r;
  assign value_o = value_r;
  assign age_o   = age_r;

endmodule

// ===== rtl/sliding_window_max_filter.sv =====
// Running maximum over the last window_size samples of a signed stream.
// Input channel: in_valid, in_stall, in_sample, in_restart. An item is taken
// at a clock edge with in_valid high and in_stall low. A set in_restart makes
// that sample the first of a new stream.
// Result channel: out_valid, out_stall, out_window_max. One result follows
// each item once window_size samples of the current stream have arrived; the
// first window_size-1 samples of a stream give none.
// The result sits in the output register the cycle after its item is taken.
// Unless a result stalls, throughput is one item per cycle, set by the row
// of candidate cells, which compare against the new sample in parallel and
// shift toward the front by at most one place per item.
// While the receiver stalls a waiting result, in_stall is high and the
// result holds. Writing cfg_wr_data with cfg_wr_en sets the window length
// (zero acts as one, values above WINDOW_MAX act as WINDOW_MAX) and restarts
// the stream. Reset empties the cells and the output and sets a window of one.
module sliding_window_max_filter
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_max,
  input  logic                          cfg_wr_en,
  input  logic [CFG_BITS-1:0]           cfg_wr_data
);

  localparam int N  = WINDOW_MAX;
  localparam int DW = SAMPLE_BITS;
  localparam int AW = $clog2(WINDOW_MAX + 1);

  logic [AW-1:0]        win_r, win_nxt;
  logic [AW-1:0]        seen_r, seen_nxt, seen_base;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_max_r, out_max_nxt;
  logic                 accept;
  swm_ctl_t             ctl;

  logic                 valid_w [N+1];
  logic signed [DW-1:0] value_w [N+1];
  logic [AW-1:0]        age_w [N+1];
  logic                 surv_w [N+1];
  logic [N:0]           valid_vec;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign ctl.flush   = cfg_wr_en;
  assign ctl.step    = accept;
  assign ctl.restart = in_restart;
  assign ctl.shift   = accept && !in_restart && valid_w[0] && (age_w[0] >= win_r);

  assign valid_w[N] = 1'b0;
  assign value_w[N] = '0;
  assign age_w[N]   = '0;
  assign surv_w[N]  = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic prev_ok;
      if (gi == 0) begin : g_first
        assign prev_ok = 1'b1;
      end else begin : g_rest
        assign prev_ok = ctl.shift ? surv_w[gi] : surv_w[gi-1];
      end
      swm_cell #(
        .DW(DW),
        .AW(AW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sample_i  (in_sample),
        .win_i     (win_r),
        .prev_ok_i (prev_ok),
        .nb_valid_i(valid_w[gi+1]),
        .nb_value_i(value_w[gi+1]),
        .nb_age_i  (age_w[gi+1]),
        .nb_surv_i (surv_w[gi+1]),
        .valid_o   (valid_w[gi]),
        .value_o   (value_w[gi]),
        .age_o     (age_w[gi]),
        .surv_o    (surv_w[gi])
      );
      assign valid_vec[gi] = valid_w[gi];
    end
  endgenerate
  assign valid_vec[N] = 1'b0;

  always_comb begin
    win_nxt       = win_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_max_nxt   = out_max_r;
    seen_base     = in_restart ? '0 : seen_r;
    if (cfg_wr_en) begin
      seen_nxt = '0;
      if (cfg_wr_data == '0) begin
        win_nxt = AW'(1);
      end else if (32'(cfg_wr_data) > 32'(WINDOW_MAX)) begin
        win_nxt = AW'(WINDOW_MAX);
      end else begin
        win_nxt = AW'(cfg_wr_data);
      end
    end else if (accept) begin
      seen_nxt = (seen_base < win_r) ? seen_base + AW'(1) : seen_base;
      out_valid_nxt = (seen_nxt >= win_r);
      if (ctl.shift) begin
        out_max_nxt = surv_w[1] ? value_w[1] : in_sample;
      end else begin
        out_max_nxt = surv_w[0] ? value_w[0] : in_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= AW'(1);
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_max_r <= out_max_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(valid_vec + (N+1)'(1)))
    else $error("candidate cells are not packed toward the front");

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) <= int'(win_r))
    else $error("more candidates than the window length");

  a_full_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_wr_en && !in_restart && (seen_r == win_r) |=> out_valid)
    else $error("item of a full window gave no result");

endmodule

// ===== dv/sliding_window_max_filter_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_max_filter_tb;
  import swm_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int WIN_DEPTH = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TARGET_ITEMS = 1750;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  class window_max_scoreboard;
    int unsigned win_len;
    sample_t stream_tail[$];
    sample_t expected_max[$];
    int errors;

    function new();
      win_len = 1;
      errors = 0;
    endfunction

    function void set_window(logic [CFG_BITS-1:0] v);
      if (v == 0) begin
        win_len = 1;
      end else if (v > WIN_DEPTH) begin
        win_len = WIN_DEPTH;
      end else begin
        win_len = 32'(v);
      end
      stream_tail.delete();
    endfunction

    function void note_sample(sample_t s, logic restart);
      sample_t peak;
      if (restart) begin
        stream_tail.delete();
      end
      stream_tail = {stream_tail, s};
      if (stream_tail.size() > win_len) begin
        stream_tail.delete(0);
      end
      if (stream_tail.size() == win_len) begin
        peak = stream_tail[0];
        foreach (stream_tail[i]) begin
          if (stream_tail[i] > peak) begin
            peak = stream_tail[i];
          end
        end
        expected_max = {expected_max, peak};
      end
    endfunction

    function int pending();
      return expected_max.size();
    endfunction

    task report(string msg);
      if (errors < 40) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_result(sample_t got);
      sample_t want;
      if (expected_max.size() == 0) begin
        report($sformatf("window_max %0d arrived with no item waiting", got));
      end else begin
        want = expected_max[0];
        expected_max.delete(0);
        if (got !== want) begin
          report($sformatf("window_max got %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t in_sample = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_window_max;
  logic cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0] cfg_wr_data = '0;

  window_max_scoreboard sb;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int run_left = 0;
  int run_mode = 0;
  int last_val = 0;

  sliding_window_max_filter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_window_max(out_window_max),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sliding_window_max_filter: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_window_max);
    end
  end

  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
    end else if (stall_left == 0) begin
      case ($urandom_range(0, 99)) inside
        [0:19]: stall_left = 1 + $urandom_range(0, 2);
        [20:22]: stall_left = $urandom_range(10, 50);
        default: stall_left = 0;
      endcase
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) begin
      stall_left--;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Runs of one kind of sample: full range, a few small values so that equal
  // samples meet, the extremes, and falling or rising ramps. Long falling
  // ramps fill the candidate row to its full depth.
  function automatic sample_t next_sample();
    int v;
    if (run_left == 0) begin
      run_mode = $urandom_range(0, 4);
      run_left = $urandom_range(1, 80);
    end
    run_left--;
    case (run_mode)
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = int'($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          default: v = 0;
        endcase
      end
      3: v = last_val - int'($urandom_range(0, 300));
      default: v = last_val + int'($urandom_range(0, 300));
    endcase
    if (v < -32768) begin
      v = -32768;
    end
    if (v > 32767) begin
      v = 32767;
    end
    last_val = v;
    return sample_t'(v);
  endfunction

  task automatic send_item(input sample_t s, input logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, restart);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_BITS-1:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(v);
  endtask

  initial begin
    int sent;
    int phase;
    int n;
    logic [CFG_BITS-1:0] wv;
    int phase_windows[8];

    sb = new();
    phase_windows = '{0, 64, 2, 127, 1, 65, 5, 16};
    sent = 0;
    phase = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Window of one straight out of reset.
    send_item(sample_t'(-32768), 1'b0);
    send_item(sample_t'(32767), 1'b0);

    write_window(CFG_BITS'(3));
    send_item(sample_t'(32767), 1'b0);
    send_item(sample_t'(-32768), 1'b0);
    send_item(sample_t'(-32768), 1'b0);
    send_item(sample_t'(-32768), 1'b0);
    send_item(sample_t'(0), 1'b0);
    send_item(sample_t'(-1), 1'b0);
    send_item(sample_t'(5), 1'b0);
    send_item(sample_t'(5), 1'b0);
    send_item(sample_t'(5), 1'b0);
    send_item(sample_t'(10), 1'b0);
    send_item(sample_t'(9), 1'b0);
    send_item(sample_t'(8), 1'b0);
    send_item(sample_t'(1), 1'b0);
    send_item(sample_t'(2), 1'b0);
    send_item(sample_t'(3), 1'b0);
    send_item(sample_t'(-32768), 1'b1);
    send_item(sample_t'(7), 1'b0);
    send_item(sample_t'(7), 1'b0);
    send_item(sample_t'(-32768), 1'b0);

    while (sent < TARGET_ITEMS) begin
      if (phase < 8) begin
        wv = CFG_BITS'(phase_windows[phase]);
      end else begin
        wv = CFG_BITS'($urandom_range(0, 127));
      end
      write_window(wv);
      idle_on = ($urandom_range(0, 3) != 0);
      n = (wv >= 32) ? 250 : 100;
      if (n > TARGET_ITEMS - sent) begin
        n = TARGET_ITEMS - sent;
      end
      repeat (n) begin
        if ($urandom_range(0, 299) == 0) begin
          drain_results();
        end
        send_item(next_sample(), $urandom_range(0, 149) == 0);
        sent++;
      end
      phase++;
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** sliding_window_max_filter: PASSED **");
    end else begin
      $display("** sliding_window_max_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_max_filter.sv
dv/sliding_window_max_filter_tb.sv
